// ===== sv/abort_escalation_mode_manager_defines.svh =====
// Assertion macros shared by the checker of the abort escalation mode manager.
`ifndef ABORT_ESCALATION_MODE_MANAGER_DEFINES_SVH
`define ABORT_ESCALATION_MODE_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AEMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AEMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aemm_pkg.sv =====
// Types, constants and helper functions of the abort escalation mode manager.
package aemm_pkg;

  // Field widths
  localparam int unsigned StepW  = 32;
  localparam int unsigned PosW   = 32;
  localparam int unsigned CountW = 20;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 3;

  // Stream widths, padded to whole bytes
  localparam int unsigned InTdataW  = 136;
  localparam int unsigned OutTdataW = 104;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegHoldTimeout    = 3'd0;
  localparam logic [IdxW-1:0] RegRetreatTimeout = 3'd1;
  localparam logic [IdxW-1:0] RegDeescalate     = 3'd2;
  localparam logic [IdxW-1:0] RegRetreatX       = 3'd3;
  localparam logic [IdxW-1:0] RegRetreatY       = 3'd4;
  localparam logic [IdxW-1:0] RegRetreatZ       = 3'd5;
  localparam logic [IdxW-1:0] RegSafeY          = 3'd6;

  // Reset values of the configuration registers
  localparam logic [StepW-1:0]  HoldTimeoutRst    = 32'd3000;
  localparam logic [StepW-1:0]  RetreatTimeoutRst = 32'd6000;
  localparam logic [CountW-1:0] DeescalateRst     = 20'd500;

  // Mode codes as they appear on the result stream
  localparam logic [CodeW-1:0] CodeNominal = 2'd0;
  localparam logic [CodeW-1:0] CodeHold    = 2'd1;
  localparam logic [CodeW-1:0] CodeRetreat = 2'd2;
  localparam logic [CodeW-1:0] CodeSafe    = 2'd3;

  // Internal one-hot mode state
  typedef enum logic [3:0] {
    ST_NOMINAL = 4'b0001,
    ST_HOLD    = 4'b0010,
    ST_RETREAT = 4'b0100,
    ST_SAFE    = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [StepW-1:0]  hold_timeout_steps;
    logic [StepW-1:0]  retreat_timeout_steps;
    logic [CountW-1:0] deescalate_steps;
    logic signed [PosW-1:0] retreat_x;
    logic signed [PosW-1:0] retreat_y;
    logic signed [PosW-1:0] retreat_z;
    logic signed [PosW-1:0] safe_y;
  } cfg_t;

  typedef struct packed {
    logic [StepW-1:0]       step_number;
    logic                   fault_active;
    logic                   fault_is_latched;
    logic signed [PosW-1:0] nav_x;
    logic signed [PosW-1:0] nav_y;
    logic signed [PosW-1:0] nav_z;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]       mode;
    logic [CodeW-1:0]       previous_mode;
    logic                   override_on;
    logic signed [PosW-1:0] override_x;
    logic signed [PosW-1:0] override_y;
    logic signed [PosW-1:0] override_z;
  } out_item_t;

  // Map the one-hot mode onto its stream code.
  function automatic logic [CodeW-1:0] mode_code(mode_e m);
    logic [CodeW-1:0] c;
    case (m)
      ST_NOMINAL: c = CodeNominal;
      ST_HOLD:    c = CodeHold;
      ST_RETREAT: c = CodeRetreat;
      ST_SAFE:    c = CodeSafe;
      default:    c = CodeNominal;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/aemm_cfg.sv =====
// Configuration register file of the abort escalation mode manager.
module aemm_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [aemm_pkg::IdxW-1:0] cfg_index_i,
  input  logic [aemm_pkg::CfgW-1:0] cfg_wdata_i,
  output aemm_pkg::cfg_t            cfg_o
);
  import aemm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write into the addressed register; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegHoldTimeout:    cfg_d.hold_timeout_steps    = cfg_wdata_i;
        RegRetreatTimeout: cfg_d.retreat_timeout_steps = cfg_wdata_i;
        RegDeescalate:     cfg_d.deescalate_steps      = cfg_wdata_i[CountW-1:0];
        RegRetreatX:       cfg_d.retreat_x             = $signed(cfg_wdata_i);
        RegRetreatY:       cfg_d.retreat_y             = $signed(cfg_wdata_i);
        RegRetreatZ:       cfg_d.retreat_z             = $signed(cfg_wdata_i);
        RegSafeY:          cfg_d.safe_y                = $signed(cfg_wdata_i);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_timeout_steps    <= HoldTimeoutRst;
      cfg_q.retreat_timeout_steps <= RetreatTimeoutRst;
      cfg_q.deescalate_steps      <= DeescalateRst;
      cfg_q.retreat_x             <= '0;
      cfg_q.retreat_y             <= '0;
      cfg_q.retreat_z             <= '0;
      cfg_q.safe_y                <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/aemm_core.sv =====
// Mode state, escalation logic and override selection for one control step.
module aemm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  aemm_pkg::in_item_t  item_i,
  input  aemm_pkg::cfg_t      cfg_i,
  output aemm_pkg::out_item_t result_o
);
  import aemm_pkg::*;

  mode_e              mode_q, mode_d;
  mode_e              last_q, last_d;
  logic [StepW-1:0]   entry_q, entry_d;
  logic [CountW-1:0]  stable_q, stable_d;
  logic [StepW-1:0]   elapsed;
  logic [CountW-1:0]  stable_inc;

  // Steps since the last transition, modulo the step counter width.
  assign elapsed    = item_i.step_number - entry_q;
  assign stable_inc = (stable_q == CountMax) ? CountMax : stable_q + 1'b1;

  // Next mode for the step held in the input register.
  always_comb begin
    mode_d   = mode_q;
    last_d   = last_q;
    entry_d  = entry_q;
    stable_d = stable_q;
    case (mode_q)
      ST_NOMINAL: begin
        if (item_i.fault_active) begin
          mode_d   = ST_HOLD;
          last_d   = ST_NOMINAL;
          entry_d  = item_i.step_number;
          stable_d = '0;
        end
      end
      ST_HOLD: begin
        if (item_i.fault_active) begin
          stable_d = '0;
          if (item_i.fault_is_latched || (elapsed > cfg_i.hold_timeout_steps)) begin
            mode_d  = ST_RETREAT;
            last_d  = ST_HOLD;
            entry_d = item_i.step_number;
          end
        end else if (stable_inc > cfg_i.deescalate_steps) begin
          mode_d   = ST_NOMINAL;
          last_d   = ST_HOLD;
          entry_d  = item_i.step_number;
          stable_d = '0;
        end else begin
          stable_d = stable_inc;
        end
      end
      ST_RETREAT: begin
        if (elapsed > cfg_i.retreat_timeout_steps) begin
          mode_d  = ST_SAFE;
          last_d  = ST_RETREAT;
          entry_d = item_i.step_number;
        end
      end
      ST_SAFE: mode_d = ST_SAFE;
      default: mode_d = ST_NOMINAL;
    endcase
  end

  // State advances only when the step moves on to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ST_NOMINAL;
      last_q   <= ST_NOMINAL;
      entry_q  <= '0;
      stable_q <= '0;
    end else if (step_en_i) begin
      mode_q   <= mode_d;
      last_q   <= last_d;
      entry_q  <= entry_d;
      stable_q <= stable_d;
    end
  end

  // Override position follows the new mode.
  always_comb begin
    result_o.mode          = mode_code(mode_d);
    result_o.previous_mode = mode_code(last_d);
    result_o.override_on   = 1'b0;
    result_o.override_x    = '0;
    result_o.override_y    = '0;
    result_o.override_z    = '0;
    case (mode_d)
      ST_HOLD: begin
        result_o.override_on = 1'b1;
        result_o.override_x  = item_i.nav_x;
        result_o.override_y  = item_i.nav_y;
        result_o.override_z  = item_i.nav_z;
      end
      ST_RETREAT: begin
        result_o.override_on = 1'b1;
        result_o.override_x  = cfg_i.retreat_x;
        result_o.override_y  = cfg_i.retreat_y;
        result_o.override_z  = cfg_i.retreat_z;
      end
      ST_SAFE: begin
        result_o.override_on = 1'b1;
        result_o.override_y  = cfg_i.safe_y;
      end
      default: result_o.override_on = 1'b0;
    endcase
  end

endmodule

// ===== sv/abort_escalation_mode_manager.sv =====
// Top level of the abort escalation mode manager: stream registers and wiring.
//
// One request on the slave stream is one control step: step number, active
// and latched fault flags and the navigated position. For every request the
// block returns exactly one result on the master stream: the new mode, the
// mode before the last transition and the guidance position override.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i while
// no step is in flight; a write takes effect at the clock edge it is sampled.
// A request accepted at a clock edge waits in the input register, its mode
// update is captured in the result register once that register is free, and
// the result is then offered on the master stream. Throughput is one step per
// cycle while the receiver does not stall, since the mode update of one step
// completes before the next step reads the state.
// When the receiver stalls, the result register holds its result and the
// input register still takes one more request; s_axis_tready falls only once
// both are full. Reset clears the mode to nominal, the entry step and the
// stability count to zero, the configuration to its defaults and both stream
// registers to empty.
module abort_escalation_mode_manager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // step_number[31:0], fault_active[32], fault_is_latched[33], nav_x[65:34],
  // nav_y[97:66], nav_z[129:98], zero padding[135:130]
  input  logic [aemm_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // mode[1:0], previous_mode[3:2], override_on[4], override_x[36:5],
  // override_y[68:37], override_z[100:69], zero padding[103:101]
  output logic [aemm_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [aemm_pkg::IdxW-1:0]      cfg_index_i,
  input  logic [aemm_pkg::CfgW-1:0]      cfg_wdata_i
);
  import aemm_pkg::*;

  localparam int unsigned OutPadW = OutTdataW - $bits(out_item_t);

  cfg_t       cfg;
  in_item_t   in_item;
  in_item_t   in_item_q;
  out_item_t  result;
  logic       in_valid_q, in_valid_d;
  logic       out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_tdata_q;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Unpack the request payload.
  assign in_item.step_number      = s_axis_tdata[31:0];
  assign in_item.fault_active     = s_axis_tdata[32];
  assign in_item.fault_is_latched = s_axis_tdata[33];
  assign in_item.nav_x            = $signed(s_axis_tdata[65:34]);
  assign in_item.nav_y            = $signed(s_axis_tdata[97:66]);
  assign in_item.nav_z            = $signed(s_axis_tdata[129:98]);

  // Pipeline handshake between the input and result registers.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item;
    end
    if (advance) begin
      out_tdata_q <= {{OutPadW{1'b0}}, result.override_z, result.override_y,
                      result.override_x, result.override_on,
                      result.previous_mode, result.mode};
    end
  end

  aemm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  aemm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

endmodule

// ===== sv/aemm_checker.sv =====
// Port-level checker of the abort escalation mode manager and its bind.
`include "abort_escalation_mode_manager_defines.svh"

module aemm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [aemm_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [aemm_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           cfg_we_i,
  input logic [aemm_pkg::IdxW-1:0]      cfg_index_i,
  input logic [aemm_pkg::CfgW-1:0]      cfg_wdata_i
);
  import aemm_pkg::*;

  logic [CodeW-1:0] res_mode;
  logic [CodeW-1:0] res_prev;
  logic             res_on;
  logic             res_pos_zero;

  assign res_mode     = m_axis_tdata[1:0];
  assign res_prev     = m_axis_tdata[3:2];
  assign res_on       = m_axis_tdata[4];
  assign res_pos_zero = (m_axis_tdata[100:5] == '0);

  // A stalled result stays put.
  `AEMM_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // The block only refuses requests while a result is waiting.
  `AEMM_ASSERT_NOW(a_ready_when_empty, !s_axis_tready, m_axis_tvalid, "request refused with no result pending")

  // Safe mode is never left.
  `AEMM_ASSERT_NEXT(a_safe_sticky, m_axis_tvalid && (res_mode == CodeSafe), !m_axis_tvalid || (res_mode == CodeSafe), "safe mode left")

  // Safe is reached from retreat only.
  `AEMM_ASSERT_NOW(a_safe_from_retreat, m_axis_tvalid && (res_mode == CodeSafe), res_prev == CodeRetreat, "safe entered from a mode other than retreat")

  // Nominal carries no override.
  `AEMM_ASSERT_NOW(a_nominal_no_override, m_axis_tvalid && (res_mode == CodeNominal), !res_on && res_pos_zero, "override shown in nominal mode")

  logic unused_inputs;
  assign unused_inputs = ^{s_axis_tvalid, s_axis_tdata, cfg_we_i, cfg_index_i, cfg_wdata_i};

endmodule

bind abort_escalation_mode_manager aemm_checker u_aemm_checker (.*);

// ===== sim/abort_escalation_mode_manager_tb.sv =====
// Self-checking stream testbench of the abort escalation mode manager.
module abort_escalation_mode_manager_tb;
  import aemm_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ReportMax  = 10;

  // Receiver stall styles
  localparam int ReadyAlways     = 0;
  localparam int ReadyCoin       = 1;
  localparam int ReadyMostly     = 2;
  localparam int ReadyEveryThird = 3;

  // Mode state as the predictor keeps it
  typedef struct packed {
    logic [CodeW-1:0]  mode;
    logic [CodeW-1:0]  last_mode;
    logic [StepW-1:0]  entry_step;
    logic [CountW-1:0] stable_count;
  } mode_state_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // step_number, fault_active, fault_is_latched, nav_x, nav_y, nav_z, padding
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // mode, previous_mode, override_on, override_x, override_y, override_z, padding
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [IdxW-1:0]      cfg_index_i = '0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;

  // Register copy, predictor state for checking and a second copy for planning
  cfg_t        mgr_cfg;
  mode_state_t check_state;
  mode_state_t plan_state;

  logic [InTdataW-1:0] ctrl_step_q[$];
  out_item_t           predicted_result_q[$];

  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_cycle = 0;
  int          ready_style = ReadyAlways;
  int          cycle_count = 0;
  int unsigned mismatch_count = 0;

  in_item_t         accepted_step;
  out_item_t        got_result;
  out_item_t        want_result;
  logic [StepW-1:0] cur_step;
  logic [StepW-1:0] escape_step;
  logic [StepW-1:0] retreat_limit;
  logic [CfgW-1:0]  rnd_word;

  abort_escalation_mode_manager DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Advance the mode state by one control step and return the result it gives.
  function automatic out_item_t predict_step(inout mode_state_t st, input in_item_t it);
    out_item_t        res;
    logic [StepW-1:0] elapsed;
    elapsed = it.step_number - st.entry_step;
    res = '0;
    case (st.mode)
      CodeNominal: begin
        if (it.fault_active) begin
          st.last_mode = CodeNominal;
          st.mode = CodeHold;
          st.entry_step = it.step_number;
          st.stable_count = '0;
        end
      end
      CodeHold: begin
        if (it.fault_active) begin
          st.stable_count = '0;
          if (it.fault_is_latched || elapsed > mgr_cfg.hold_timeout_steps) begin
            st.last_mode = CodeHold;
            st.mode = CodeRetreat;
            st.entry_step = it.step_number;
          end
        end else begin
          if (st.stable_count != CountMax) st.stable_count = st.stable_count + 1'b1;
          if (st.stable_count > mgr_cfg.deescalate_steps) begin
            st.last_mode = CodeHold;
            st.mode = CodeNominal;
            st.entry_step = it.step_number;
            st.stable_count = '0;
          end
        end
      end
      CodeRetreat: begin
        if (elapsed > mgr_cfg.retreat_timeout_steps) begin
          st.last_mode = CodeRetreat;
          st.mode = CodeSafe;
          st.entry_step = it.step_number;
        end
      end
      default: ;
    endcase
    res.mode = st.mode;
    res.previous_mode = st.last_mode;
    // The override point follows the mode just entered.
    case (st.mode)
      CodeHold: begin
        res.override_on = 1'b1;
        res.override_x = it.nav_x;
        res.override_y = it.nav_y;
        res.override_z = it.nav_z;
      end
      CodeRetreat: begin
        res.override_on = 1'b1;
        res.override_x = mgr_cfg.retreat_x;
        res.override_y = mgr_cfg.retreat_y;
        res.override_z = mgr_cfg.retreat_z;
      end
      CodeSafe: begin
        res.override_on = 1'b1;
        res.override_y = mgr_cfg.safe_y;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random position, with a bias towards the extremes of Q16.16.
  function automatic logic signed [PosW-1:0] rand_pos();
    logic signed [PosW-1:0] p;
    case ($urandom_range(0, 7))
      0: p = 32'h7FFF_FFFF;
      1: p = 32'h8000_0000;
      2: p = '0;
      3: p = '1;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // One random bit.
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Write one register while the block is idle and keep the local copy in step.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegHoldTimeout:    mgr_cfg.hold_timeout_steps = val;
      RegRetreatTimeout: mgr_cfg.retreat_timeout_steps = val;
      RegDeescalate:     mgr_cfg.deescalate_steps = val[CountW-1:0];
      RegRetreatX:       mgr_cfg.retreat_x = val;
      RegRetreatY:       mgr_cfg.retreat_y = val;
      RegRetreatZ:       mgr_cfg.retreat_z = val;
      RegSafeY:          mgr_cfg.safe_y = val;
      default: ;
    endcase
  endtask

  // The de-escalation register keeps 20 bits; the upper bits of the word are noise.
  task automatic write_deescalate(input logic [CountW-1:0] val);
    rnd_word = $urandom;
    write_reg(RegDeescalate, {rnd_word[CfgW-1:CountW], val});
  endtask

  // Queue one control step and track the mode it leads to.
  task automatic plan_step(input logic [StepW-1:0] step, input logic act, input logic lat,
                           input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y,
                           input logic signed [PosW-1:0] z);
    in_item_t  it;
    it.step_number = step;
    it.fault_active = act;
    it.fault_is_latched = lat;
    it.nav_x = x;
    it.nav_y = y;
    it.nav_z = z;
    void'(predict_step(plan_state, it));
    ctrl_step_q.push_back({6'b0, z, y, x, lat, act, step});
  endtask

  // Hold off until every request has gone out and every result has come back.
  task automatic wait_idle();
    while (ctrl_step_q.size() != 0 || s_axis_tvalid || predicted_result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Runs of steps with a varying fault rate, kept between nominal and hold.
  task automatic plan_random_steps(input int count);
    int               run_left;
    int               fault_pct;
    int               r;
    logic             act;
    logic             lat;
    logic [StepW-1:0] elapsed;
    run_left = 0;
    fault_pct = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 30);
        case ($urandom_range(0, 3))
          0: fault_pct = 0;
          1: fault_pct = 10;
          2: fault_pct = 30;
          default: fault_pct = 70;
        endcase
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 75) cur_step = cur_step + 1;
      else if (r >= 85 && r < 93) cur_step = cur_step + $urandom_range(2, 50);
      else if (r >= 93) cur_step = $urandom;
      act = ($urandom_range(0, 99) < fault_pct);
      lat = rand_bit();
      elapsed = cur_step - plan_state.entry_step;
      // Retreat is one-way, so escalation is saved for the closing phase.
      if (plan_state.mode == CodeHold && act && elapsed > mgr_cfg.hold_timeout_steps)
        act = 1'b0;
      if (plan_state.mode == CodeHold && act) lat = 1'b0;
      plan_step(cur_step, act, lat, rand_pos(), rand_pos(), rand_pos());
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (ctrl_step_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ctrl_step_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a random stall style, redrawn at regular intervals.
  always @(posedge clk_i) begin
    ready_cycle = ready_cycle + 1;
    if (ready_cycle % 48 == 0) ready_style = $urandom_range(ReadyAlways, ReadyEveryThird);
    case (ready_style)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyCoin:   m_axis_tready <= rand_bit();
      ReadyMostly: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default:     m_axis_tready <= (ready_cycle % 3 == 0);
    endcase
  end

  // Every accepted request gives one predicted result.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accepted_step.step_number = s_axis_tdata[31:0];
      accepted_step.fault_active = s_axis_tdata[32];
      accepted_step.fault_is_latched = s_axis_tdata[33];
      accepted_step.nav_x = s_axis_tdata[65:34];
      accepted_step.nav_y = s_axis_tdata[97:66];
      accepted_step.nav_z = s_axis_tdata[129:98];
      predicted_result_q.push_back(predict_step(check_state, accepted_step));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.mode = m_axis_tdata[1:0];
      got_result.previous_mode = m_axis_tdata[3:2];
      got_result.override_on = m_axis_tdata[4];
      got_result.override_x = m_axis_tdata[36:5];
      got_result.override_y = m_axis_tdata[68:37];
      got_result.override_z = m_axis_tdata[100:69];
      if (predicted_result_q.size() == 0) begin
        if (mismatch_count < ReportMax)
          $display("unexpected result: mode %0d prev %0d on %0d x %h y %h z %h",
                   got_result.mode, got_result.previous_mode, got_result.override_on,
                   got_result.override_x, got_result.override_y, got_result.override_z);
        mismatch_count++;
      end else begin
        want_result = predicted_result_q.pop_front();
        if (got_result !== want_result) begin
          if (mismatch_count < ReportMax) begin
            $write("mismatch: expected mode %0d prev %0d on %0d x %h y %h z %h, ",
                   want_result.mode, want_result.previous_mode, want_result.override_on,
                   want_result.override_x, want_result.override_y, want_result.override_z);
            $display("got mode %0d prev %0d on %0d x %h y %h z %h",
                     got_result.mode, got_result.previous_mode, got_result.override_on,
                     got_result.override_x, got_result.override_y, got_result.override_z);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mgr_cfg.hold_timeout_steps = HoldTimeoutRst;
    mgr_cfg.retreat_timeout_steps = RetreatTimeoutRst;
    mgr_cfg.deescalate_steps = DeescalateRst;
    mgr_cfg.retreat_x = '0;
    mgr_cfg.retreat_y = '0;
    mgr_cfg.retreat_z = '0;
    mgr_cfg.safe_y = '0;
    check_state = '0;
    plan_state = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: latched without active, the hold timeout boundary, nav extremes.
    plan_step(32'd0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    plan_step(32'd1, 1'b0, 1'b1, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    plan_step(32'd2, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    plan_step(32'd3, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_step(32'd3002, 1'b1, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    plan_step(32'd3003, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    wait_idle();

    // Return to nominal across the step number wrap, hold timeout at its top.
    write_reg(RegHoldTimeout, 32'hFFFF_FFFF);
    write_deescalate(20'd2);
    plan_step(32'hFFFF_FFFF, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd0, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd1, 1'b0, 1'b1, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd2, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd3, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    wait_idle();

    // Zero timeout and zero threshold: equal step numbers must not escalate.
    write_reg(RegHoldTimeout, 32'd0);
    write_deescalate(20'd0);
    plan_step(32'd4, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd4, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd4, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd5, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos());
    cur_step = 32'd5;
    wait_idle();

    // Random phases between nominal and hold under several settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(RegHoldTimeout, $urandom_range(0, 3));
          write_deescalate(20'd0);
        end
        1: begin
          write_reg(RegHoldTimeout, $urandom_range(4, 40));
          write_deescalate(CountW'($urandom_range(1, 6)));
        end
        2: begin
          write_reg(RegHoldTimeout, 32'hFFFF_FFFF);
          write_deescalate(CountW'($urandom_range(0, 20)));
        end
        3: begin
          write_reg(RegHoldTimeout, $urandom);
          write_deescalate(CountW'($urandom_range(0, 3)));
        end
        default: begin
          write_reg(RegHoldTimeout, $urandom_range(0, 15));
          write_deescalate(CountW'($urandom_range(0, 40)));
        end
      endcase
      write_reg(RegRetreatTimeout, $urandom);
      write_reg(IdxW'($urandom_range(RegRetreatX, RegSafeY)), rand_pos());
      plan_random_steps(100);
      wait_idle();
    end

    // Settle in nominal before the closing phase.
    write_deescalate(20'd0);
    cur_step = cur_step + 1;
    plan_step(cur_step, 1'b0, rand_bit(), rand_pos(), rand_pos(), rand_pos());
    wait_idle();

    // Escalation: hold never clears, elapsed count wraps, the boundary holds.
    write_reg(RegHoldTimeout, 32'd5);
    write_deescalate(CountMax);
    write_reg(RegRetreatTimeout, 32'hFFFF_FFFF);
    write_reg(RegRetreatX, 32'h7FFF_FFFF);
    write_reg(RegRetreatY, 32'h8000_0000);
    write_reg(RegRetreatZ, $urandom);
    plan_step(32'hFFFF_FFFD, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'hFFFF_FFFE, 1'b0, 1'b1, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'hFFFF_FFFF, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd0, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd1, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos());
    plan_step(32'd2, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    // Into retreat either by a latched fault or by the hold timeout.
    if ($urandom_range(0, 1) == 0) begin
      escape_step = 32'd2;
      plan_step(escape_step, 1'b1, 1'b1, rand_pos(), rand_pos(), rand_pos());
    end else begin
      escape_step = 32'd3;
      plan_step(escape_step, 1'b1, 1'b0, rand_pos(), rand_pos(), rand_pos());
    end
    // In retreat the fault inputs count for nothing; the timeout cannot fire yet.
    for (int i = 0; i < 20; i++)
      plan_step($urandom, rand_bit(), rand_bit(), rand_pos(), rand_pos(), rand_pos());
    wait_idle();

    // Retreat up to its timeout, then one step past it into safe.
    retreat_limit = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 30);
    write_reg(RegRetreatTimeout, retreat_limit);
    write_reg(RegRetreatX, rand_pos());
    write_reg(RegRetreatY, rand_pos());
    write_reg(RegRetreatZ, rand_pos());
    for (int k = 0; k <= retreat_limit; k++)
      plan_step(escape_step + k, rand_bit(), rand_bit(), rand_pos(), rand_pos(), rand_pos());
    plan_step(escape_step + retreat_limit + 1, rand_bit(), rand_bit(),
              rand_pos(), rand_pos(), rand_pos());
    for (int i = 0; i < 20; i++)
      plan_step($urandom, rand_bit(), rand_bit(), rand_pos(), rand_pos(), rand_pos());
    wait_idle();

    // Safe is sticky whatever the registers say.
    write_reg(RegSafeY, 32'h8000_0000);
    write_reg(RegHoldTimeout, 32'd0);
    write_reg(RegRetreatTimeout, 32'd0);
    write_deescalate(20'd0);
    for (int i = 0; i < 20; i++)
      plan_step($urandom, rand_bit(), rand_bit(), rand_pos(), rand_pos(), rand_pos());
    wait_idle();
    write_reg(RegSafeY, 32'h7FFF_FFFF);
    for (int i = 0; i < 10; i++)
      plan_step($urandom, rand_bit(), rand_bit(), rand_pos(), rand_pos(), rand_pos());
    wait_idle();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && predicted_result_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/aemm_pkg.sv
sv/aemm_cfg.sv
sv/aemm_core.sv
sv/abort_escalation_mode_manager.sv
sv/aemm_checker.sv
sim/abort_escalation_mode_manager_tb.sv
